FILE: rtl/sparse_column_store_macros.svh
// Assertion macros shared by the sparse column store RTL.
// Clocked property wrappers; they compile to nothing when SYNTH is defined.
`ifndef SPARSE_COLUMN_STORE_MACROS_SVH
`define SPARSE_COLUMN_STORE_MACROS_SVH
`ifndef SYNTH
`define SCS_ASSERT(lbl, clk, rstn, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
        else $error("scs assertion failed");
`define SCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("scs implication failed");
`define SCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("scs next-cycle check failed");
`else
`define SCS_ASSERT(lbl, clk, rstn, expr)
`define SCS_ASSERT_IMPL(lbl, clk, rstn, ante, cons)
`define SCS_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: rtl/scs_pkg.sv
// Package for the sparse column store: request and result types and codes.
// No dependencies.
package scs_pkg;

    localparam int VALUE_W   = 64;
    localparam int ARG_W     = 32;
    localparam int CNT_OUT_W = 11;

    localparam logic [1:0] REQ_APPEND   = 2'd0;
    localparam logic [1:0] REQ_DEFAULTS = 2'd1;
    localparam logic [1:0] REQ_READ     = 2'd2;
    localparam logic [1:0] REQ_TRUNC    = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_RANGE = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [VALUE_W-1:0] value;
        logic [ARG_W-1:0]   row_or_count;
    } t_req;

    typedef struct packed {
        logic [VALUE_W-1:0]   read_value;
        logic                 is_default;
        logic [1:0]           status;
        logic [ARG_W-1:0]     row_count;
        logic [CNT_OUT_W-1:0] stored_count;
    } t_res;

endpackage

FILE: rtl/sparse_column_store.sv
// Channel   Dir  tdata                                          tuser
// s_axis    in   value[63:0] row_or_count[95:64]              req_type[1:0]
// m_axis    out  read_value[63:0] row_count[95:64]            is_default[0]
//                stored_count[106:96] (zero fill to 112)       status[2:1]
// Append, append-defaults and errors go from accept straight to S_DONE.
// A read is a binary search with one memory read and one shared subtract per
// search step, then a hit check; truncate pops trailing entries one at a time.
// Reset is synchronous, active low; the column starts empty with no clearing pass.
// A new beat is taken while the previous result waits in the output register.
// Top level of the sparse column store; uses scs_pkg and scs_seq.
module sparse_column_store #(
    parameter int CAPACITY = 1024,
    parameter int ROW_BITS = 32
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [95:0]  s_axis_tdata,  // value, row_or_count
    input  logic [1:0]   s_axis_tuser,  // req_type
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    output logic [111:0] m_axis_tdata,  // read_value, row_count, stored_count
    output logic [2:0]   m_axis_tuser   // is_default, status
);
    import scs_pkg::*;

    t_req  w_req;
    t_res  w_res;
    t_res  r_out;
    logic  r_out_valid;
    logic  w_idle, w_done, w_start, w_out_free;

    always_comb begin
        w_req.req_type     = s_axis_tuser;
        w_req.value        = s_axis_tdata[VALUE_W-1:0];
        w_req.row_or_count = s_axis_tdata[VALUE_W+ARG_W-1:VALUE_W];
    end

    assign s_axis_tready = w_idle;
    assign w_start       = s_axis_tvalid && w_idle;
    assign w_out_free    = !r_out_valid || m_axis_tready;

    scs_seq #(.CAPACITY(CAPACITY), .ROW_BITS(ROW_BITS)) u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_start),
        .i_req      (w_req),
        .i_out_free (w_out_free),
        .o_idle     (w_idle),
        .o_done     (w_done),
        .o_res      (w_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_done) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'b0, r_out.stored_count, r_out.row_count, r_out.read_value};
    assign m_axis_tuser  = {r_out.status, r_out.is_default};

endmodule

FILE: rtl/scs_alu.sv
// Shared add/subtract unit of the sparse column store, one extra carry bit.
// Depends on scs_pkg for the operation codes.
module scs_alu #(
    parameter int W = 32
) (
    input  logic         i_op,
    input  logic [W-1:0] i_a,
    input  logic [W-1:0] i_b,
    output logic [W:0]   o_res
);
    import scs_pkg::*;

    always_comb begin
        if (i_op == ALU_SUB) begin
            o_res = {1'b0, i_a} - {1'b0, i_b};
        end else begin
            o_res = {1'b0, i_a} + {1'b0, i_b};
        end
    end

endmodule

FILE: rtl/scs_store.sv
// Entry memory of the sparse column store: row positions and values.
// One write port and one read port with registered read data; no dependencies.
module scs_store #(
    parameter int CAPACITY = 1024,
    parameter int ROW_BITS = 32,
    parameter int VAL_W    = 64
) (
    input  logic                        i_clk,
    input  logic                        i_we,
    input  logic [$clog2(CAPACITY)-1:0] i_waddr,
    input  logic [ROW_BITS-1:0]         i_wpos,
    input  logic [VAL_W-1:0]            i_wval,
    input  logic [$clog2(CAPACITY)-1:0] i_raddr,
    output logic [ROW_BITS-1:0]         o_rpos,
    output logic [VAL_W-1:0]            o_rval
);
    logic [ROW_BITS-1:0] r_pos_mem [CAPACITY];
    logic [VAL_W-1:0]    r_val_mem [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_pos_mem[i_waddr] <= i_wpos;
            r_val_mem[i_waddr] <= i_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rpos <= r_pos_mem[i_raddr];
        o_rval <= r_val_mem[i_raddr];
    end

endmodule

FILE: rtl/scs_seq.sv
// Request sequencer of the sparse column store: row count, entry count,
// binary search and trailing pop. Uses scs_pkg, scs_alu, scs_store and the macros.
`include "sparse_column_store_macros.svh"
module scs_seq #(
    parameter int CAPACITY = 1024,
    parameter int ROW_BITS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  scs_pkg::t_req i_req,
    input  logic          i_out_free,
    output logic          o_idle,
    output logic          o_done,
    output scs_pkg::t_res o_res
);
    import scs_pkg::*;

    localparam int IW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int AW = (ROW_BITS > ARG_W) ? ROW_BITS : ARG_W;
    localparam int EW = (CW > CNT_OUT_W) ? CW : CNT_OUT_W;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SRCH = 3'd1;
    localparam logic [2:0] S_SCMP = 3'd2;
    localparam logic [2:0] S_HIT  = 3'd3;
    localparam logic [2:0] S_TRD  = 3'd4;
    localparam logic [2:0] S_TCMP = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [2:0]          r_state, n_state;
    logic [ROW_BITS-1:0] r_total, n_total;
    logic [CW-1:0]       r_cnt, n_cnt;
    logic [CW-1:0]       r_lo, n_lo;
    logic [CW-1:0]       r_hi, n_hi;
    logic [ROW_BITS-1:0] r_arg, n_arg;
    logic [1:0]          r_status, n_status;
    logic [VALUE_W-1:0]  r_rd, n_rd;
    logic                r_dflt, n_dflt;

    logic                w_op;
    logic [AW-1:0]       w_a, w_b;
    logic [AW:0]         w_res;
    logic                w_borrow, w_zero;
    logic [AW-1:0]       w_arg_ext, w_total_ext, w_rpos_ext;
    logic [EW-1:0]       w_cnt_ext;
    logic [CW:0]         w_mid_sum;
    logic [IW-1:0]       w_mid;
    logic [CW-1:0]       w_last;
    logic                w_we;
    logic [IW-1:0]       w_raddr;
    logic [ROW_BITS-1:0] w_rpos;
    logic [VALUE_W-1:0]  w_rval;

    assign w_arg_ext   = AW'(i_req.row_or_count);
    assign w_total_ext = AW'(r_total);
    assign w_rpos_ext  = AW'(w_rpos);
    assign w_cnt_ext   = EW'(r_cnt);
    assign w_mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign w_mid       = w_mid_sum[IW:1];
    assign w_last      = r_cnt - CW'(1);
    assign w_borrow    = w_res[AW];
    assign w_zero      = (w_res[AW-1:0] == '0);

    scs_alu #(.W(AW)) u_alu (
        .i_op  (w_op),
        .i_a   (w_a),
        .i_b   (w_b),
        .o_res (w_res)
    );

    scs_store #(.CAPACITY(CAPACITY), .ROW_BITS(ROW_BITS), .VAL_W(VALUE_W)) u_store (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (r_cnt[IW-1:0]),
        .i_wpos  (r_total),
        .i_wval  (i_req.value),
        .i_raddr (w_raddr),
        .o_rpos  (w_rpos),
        .o_rval  (w_rval)
    );

    always_comb begin
        w_op = ALU_SUB;
        w_a  = w_rpos_ext;
        w_b  = AW'(r_arg);
        unique case (r_state)
            S_IDLE: begin
                unique case (i_req.req_type)
                    REQ_APPEND: begin
                        w_op = ALU_ADD;
                        w_a  = w_total_ext;
                        w_b  = AW'(1);
                    end
                    REQ_DEFAULTS: begin
                        w_op = ALU_ADD;
                        w_a  = w_total_ext;
                        w_b  = w_arg_ext;
                    end
                    REQ_READ: begin
                        w_a = w_arg_ext;
                        w_b = w_total_ext;
                    end
                    REQ_TRUNC: begin
                        w_a = w_total_ext;
                        w_b = w_arg_ext;
                    end
                    default: ;
                endcase
            end
            S_TCMP: w_b = w_total_ext;
            default: ;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_total  = r_total;
        n_cnt    = r_cnt;
        n_lo     = r_lo;
        n_hi     = r_hi;
        n_arg    = r_arg;
        n_status = r_status;
        n_rd     = r_rd;
        n_dflt   = r_dflt;
        w_we     = 1'b0;
        w_raddr  = w_mid;
        o_done   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_status = ST_OK;
                    n_rd     = '0;
                    n_dflt   = 1'b0;
                    n_state  = S_DONE;
                    unique case (i_req.req_type)
                        REQ_APPEND: begin
                            if (&r_total) begin
                                n_status = ST_RANGE;
                            end else if (|i_req.value) begin
                                if (r_cnt == CW'(CAPACITY)) begin
                                    n_status = ST_FULL;
                                end else begin
                                    w_we    = 1'b1;
                                    n_cnt   = r_cnt + CW'(1);
                                    n_total = w_res[ROW_BITS-1:0];
                                end
                            end else begin
                                n_total = w_res[ROW_BITS-1:0];
                            end
                        end
                        REQ_DEFAULTS: begin
                            if ((w_res >> ROW_BITS) != '0) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_total = w_res[ROW_BITS-1:0];
                            end
                        end
                        REQ_READ: begin
                            if (!w_borrow) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_arg   = w_arg_ext[ROW_BITS-1:0];
                                n_lo    = '0;
                                n_hi    = r_cnt;
                                n_state = S_SRCH;
                            end
                        end
                        REQ_TRUNC: begin
                            if (w_borrow) begin
                                n_status = ST_RANGE;
                            end else begin
                                n_total = w_res[ROW_BITS-1:0];
                                n_state = S_TRD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_SRCH: begin
                if (r_lo < r_hi) begin
                    n_state = S_SCMP;
                end else if (r_lo < r_cnt) begin
                    w_raddr = r_lo[IW-1:0];
                    n_state = S_HIT;
                end else begin
                    n_dflt  = 1'b1;
                    n_state = S_DONE;
                end
            end
            S_SCMP: begin
                if (w_borrow) begin
                    n_lo = CW'(w_mid) + CW'(1);
                end else begin
                    n_hi = CW'(w_mid);
                end
                n_state = S_SRCH;
            end
            S_HIT: begin
                if (!w_borrow && w_zero) begin
                    n_rd = w_rval;
                end else begin
                    n_dflt = 1'b1;
                end
                n_state = S_DONE;
            end
            S_TRD: begin
                if (r_cnt != '0) begin
                    w_raddr = w_last[IW-1:0];
                    n_state = S_TCMP;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_TCMP: begin
                if (!w_borrow) begin
                    n_cnt   = w_last;
                    n_state = S_TRD;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (i_out_free) begin
                    o_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_total <= '0;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_total <= n_total;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo     <= n_lo;
        r_hi     <= n_hi;
        r_arg    <= n_arg;
        r_status <= n_status;
        r_rd     <= n_rd;
        r_dflt   <= n_dflt;
    end

    assign o_idle = (r_state == S_IDLE);

    always_comb begin
        o_res.read_value   = r_rd;
        o_res.is_default   = r_dflt;
        o_res.status       = r_status;
        o_res.row_count    = w_total_ext[ARG_W-1:0];
        o_res.stored_count = w_cnt_ext[CNT_OUT_W-1:0];
    end

    `SCS_ASSERT(a_cnt_bound, i_clk, i_rst_n, r_cnt <= CW'(CAPACITY))
    `SCS_ASSERT_IMPL(a_search_window, i_clk, i_rst_n,
        (r_state == S_SRCH) || (r_state == S_SCMP), (r_lo <= r_hi) && (r_hi <= r_cnt))
    `SCS_ASSERT_IMPL(a_pop_nonempty, i_clk, i_rst_n, r_state == S_TCMP, r_cnt != '0)
    `SCS_ASSERT_NEXT(a_start_leaves_idle, i_clk, i_rst_n,
        (r_state == S_IDLE) && i_start, r_state != S_IDLE)

endmodule

FILE: dv/tb_sparse_column_store.sv
// Self-checking testbench for sparse_column_store: directed and random requests
// are checked against a table or shadow model. Depends on scs_pkg and the RTL.
`timescale 1ns / 1ps

module tb_sparse_column_store;
    import scs_pkg::*;

    localparam int          CAP       = 1024;
    localparam logic [31:0] ROW_MAX   = 32'hFFFF_FFFF;
    localparam int          N_DIR     = 25;
    localparam int          N_RAND    = 725;
    localparam int          IDLE_MAX  = 20000;
    localparam int          SRC_TABLE = 0;
    localparam int          SRC_RAND  = 1;

    typedef struct {
        t_req req;
        bit   known;
        t_res res;
    } t_dir_row;

    logic         i_clk         = 1'b0;
    logic         i_rst_n       = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [95:0]  s_axis_tdata  = '0;  // value, row_or_count
    logic [1:0]   s_axis_tuser  = '0;  // req_type
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [111:0] m_axis_tdata;        // read_value, row_count, stored_count
    logic [2:0]   m_axis_tuser;        // is_default, status

    logic [31:0] shadow_pos [CAP];
    logic [63:0] shadow_val [CAP];
    logic [31:0] shadow_rows = '0;
    int unsigned shadow_cnt  = 0;

    t_res     pending_results[$];
    t_dir_row dir_tab[N_DIR];
    bit       cur_known = 1'b0;
    t_res     cur_res;
    bit       steady = 1'b0;
    int       errors = 0;
    int       idle_cycles = 0;
    int       stall_left = 0;
    int       n_accepted = 0;
    int       n_checked = 0;
    int       req_tally[4] = '{default: 0};
    int       st_tally[4] = '{default: 0};

    sparse_column_store dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 i_clk = ~i_clk;

    function automatic t_res column_predict(t_req r);
        t_res res;
        res = '0;
        res.status = ST_OK;
        case (r.req_type)
            REQ_APPEND: begin
                if (shadow_rows == ROW_MAX) begin
                    res.status = ST_RANGE;
                end else if (r.value != '0) begin
                    if (shadow_cnt >= CAP) begin
                        res.status = ST_FULL;
                    end else begin
                        shadow_pos[shadow_cnt] = shadow_rows;
                        shadow_val[shadow_cnt] = r.value;
                        shadow_cnt++;
                        shadow_rows++;
                    end
                end else begin
                    shadow_rows++;
                end
            end
            REQ_DEFAULTS: begin
                if (r.row_or_count > ROW_MAX - shadow_rows) res.status = ST_RANGE;
                else shadow_rows += r.row_or_count;
            end
            REQ_READ: begin
                if (r.row_or_count >= shadow_rows) begin
                    res.status = ST_RANGE;
                end else begin
                    res.is_default = 1'b1;
                    for (int i = 0; i < shadow_cnt; i++) begin
                        if (shadow_pos[i] == r.row_or_count) begin
                            res.is_default = 1'b0;
                            res.read_value = shadow_val[i];
                        end
                    end
                end
            end
            default: begin
                if (r.row_or_count > shadow_rows) begin
                    res.status = ST_RANGE;
                end else begin
                    shadow_rows -= r.row_or_count;
                    while (shadow_cnt > 0 && shadow_pos[shadow_cnt-1] >= shadow_rows)
                        shadow_cnt--;
                end
            end
        endcase
        res.row_count    = shadow_rows;
        res.stored_count = shadow_cnt[10:0];
        return res;
    endfunction

    function automatic void put_row(int k, logic [1:0] rq, logic [63:0] v, logic [31:0] a,
                                    bit known, logic [63:0] rd, bit d, logic [1:0] st,
                                    logic [31:0] rw, logic [10:0] c);
        dir_tab[k].req   = '{req_type: rq, value: v, row_or_count: a};
        dir_tab[k].known = known;
        dir_tab[k].res   = '{read_value: rd, is_default: d, status: st,
                             row_count: rw, stored_count: c};
    endfunction

    function automatic void load_dir_tab();
        put_row(0,  REQ_READ,     64'h0, 32'h0, 1, 64'h0, 0, ST_RANGE, 0, 0);
        put_row(1,  REQ_TRUNC,    64'h0, 32'h0, 1, 64'h0, 0, ST_OK, 0, 0);
        put_row(2,  REQ_TRUNC,    '1,    32'h1, 1, 64'h0, 0, ST_RANGE, 0, 0);
        put_row(3,  REQ_DEFAULTS, 64'h0, 32'h0, 1, 64'h0, 0, ST_OK, 0, 0);
        put_row(4,  REQ_APPEND,   64'h0, '1,    1, 64'h0, 0, ST_OK, 1, 0);
        put_row(5,  REQ_APPEND,   '1,    32'h0, 1, 64'h0, 0, ST_OK, 2, 1);
        put_row(6,  REQ_APPEND,   64'h1, 32'h0, 1, 64'h0, 0, ST_OK, 3, 2);
        put_row(7,  REQ_READ,     '1,    32'h0, 1, 64'h0, 1, ST_OK, 3, 2);
        put_row(8,  REQ_READ,     64'h0, 32'h1, 1, '1,    0, ST_OK, 3, 2);
        put_row(9,  REQ_READ,     64'h0, 32'h2, 1, 64'h1, 0, ST_OK, 3, 2);
        put_row(10, REQ_READ,     64'h0, 32'h3, 1, 64'h0, 0, ST_RANGE, 3, 2);
        put_row(11, REQ_DEFAULTS, 64'h0, 32'h5, 0, 64'h0, 0, ST_OK, 0, 0);
        put_row(12, REQ_APPEND, 64'h8000_0000_0000_0000, 32'h0, 0, 64'h0, 0, ST_OK, 0, 0);
        put_row(13, REQ_READ,     64'h0, 32'h8, 0, 64'h0, 0, ST_OK, 0, 0);
        put_row(14, REQ_READ,     64'h0, 32'h7, 0, 64'h0, 0, ST_OK, 0, 0);
        put_row(15, REQ_TRUNC,    64'h0, 32'h1, 0, 64'h0, 0, ST_OK, 0, 0);
        put_row(16, REQ_TRUNC,    64'h0, 32'h8, 1, 64'h0, 0, ST_OK, 0, 0);
        put_row(17, REQ_DEFAULTS, 64'h0, '1,    1, 64'h0, 0, ST_OK, '1, 0);
        put_row(18, REQ_APPEND,   64'h5, 32'h0, 1, 64'h0, 0, ST_RANGE, '1, 0);
        put_row(19, REQ_APPEND,   64'h0, 32'h0, 1, 64'h0, 0, ST_RANGE, '1, 0);
        put_row(20, REQ_DEFAULTS, 64'h0, 32'h1, 1, 64'h0, 0, ST_RANGE, '1, 0);
        put_row(21, REQ_DEFAULTS, 64'h0, 32'h0, 1, 64'h0, 0, ST_OK, '1, 0);
        put_row(22, REQ_READ,     64'h0, 32'hFFFF_FFFE, 0, 64'h0, 0, ST_OK, 0, 0);
        put_row(23, REQ_READ,     64'h0, '1,    1, 64'h0, 0, ST_RANGE, '1, 0);
        put_row(24, REQ_TRUNC,    64'h0, '1,    1, 64'h0, 0, ST_OK, 0, 0);
    endfunction

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int   pick;
        int   sel;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        r.value        = {$urandom, $urandom};
        r.row_or_count = $urandom;
        if (pick < 35) begin
            r.req_type = REQ_APPEND;
            if (sel < 15) r.value = '0;
            else if (sel < 18) r.value = '1;
            else if (sel < 20) r.value = 64'h8000_0000_0000_0000;
        end else if (pick < 50) begin
            r.req_type = REQ_DEFAULTS;
            if (sel < 70) r.row_or_count = $urandom_range(0, 4);
            else if (sel < 90) r.row_or_count = $urandom_range(5, 200);
            else if (sel < 97) r.row_or_count = $urandom;
            else r.row_or_count = ROW_MAX - shadow_rows;
        end else if (pick < 80) begin
            r.req_type = REQ_READ;
            if (sel < 40 && shadow_cnt > 0)
                r.row_or_count = shadow_pos[$urandom_range(0, shadow_cnt - 1)];
            else if (sel < 75 && shadow_rows > 0)
                r.row_or_count = $urandom_range(0, shadow_rows - 1);
            else if (sel < 90)
                r.row_or_count = shadow_rows + $urandom_range(0, 3);
        end else begin
            r.req_type = REQ_TRUNC;
            if (sel < 50)
                r.row_or_count = (shadow_rows < 4) ? $urandom_range(0, shadow_rows)
                                                   : $urandom_range(0, 4);
            else if (sel < 70)
                r.row_or_count = 32'({32'h0, $urandom} % ({32'h0, shadow_rows} + 64'h1));
            else if (sel < 80)
                r.row_or_count = shadow_rows;
            else if (sel < 90)
                r.row_or_count = shadow_rows + $urandom_range(1, 8);
        end
        return r;
    endfunction

    task automatic send_item(input int src, input int k);
        int   gap;
        t_req r;
        gap = steady ? 0 : gap_len();
        repeat (gap) begin
            @(negedge i_clk);
            s_axis_tvalid <= 1'b0;
        end
        @(negedge i_clk);
        cur_known = 1'b0;
        if (src == SRC_TABLE) begin
            r         = dir_tab[k].req;
            cur_known = dir_tab[k].known;
            cur_res   = dir_tab[k].res;
        end else begin
            r = rand_req();
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {r.row_or_count, r.value};
        s_axis_tuser  <= r.req_type;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic drain_results();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic void check_field(string name, logic [63:0] e, logic [63:0] a);
        if (e !== a) begin
            $error("%s mismatch: expected %0h, actual %0h", name, e, a);
            errors++;
        end
    endfunction

    always @(negedge i_clk) begin
        if (stall_left > 0) begin
            m_axis_tready <= 1'b0;
            stall_left--;
        end else begin
            m_axis_tready <= 1'b1;
            if (!steady && $urandom_range(0, 3) == 0) stall_left = gap_len();
        end
    end

    always @(posedge i_clk) begin
        t_res e;
        t_req r;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (pending_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    errors++;
                end else begin
                    e = pending_results.pop_front();
                    check_field("read_value", e.read_value, m_axis_tdata[63:0]);
                    check_field("is_default", e.is_default, m_axis_tuser[0]);
                    check_field("status", e.status, m_axis_tuser[2:1]);
                    check_field("row_count", e.row_count, m_axis_tdata[95:64]);
                    check_field("stored_count", e.stored_count, m_axis_tdata[106:96]);
                    st_tally[e.status]++;
                    n_checked++;
                end
            end
            if (s_axis_tvalid && s_axis_tready) begin
                r.req_type     = s_axis_tuser;
                r.value        = s_axis_tdata[63:0];
                r.row_or_count = s_axis_tdata[95:64];
                e = column_predict(r);
                pending_results = {pending_results, (cur_known ? cur_res : e)};
                req_tally[r.req_type]++;
                n_accepted++;
            end
            if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_MAX) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    initial begin
        load_dir_tab();
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (int k = 0; k < N_DIR; k++) send_item(SRC_TABLE, k);

        for (int i = 0; i < N_RAND; i++) begin
            steady = ((i / 100) % 3 == 2);
            if (i == N_RAND / 2) drain_results();
            send_item(SRC_RAND, i);
        end
        steady = 1'b0;

        drain_results();
        repeat (40) @(posedge i_clk);
        $display("summary: %0d requests (%0d append, %0d defaults, %0d read, %0d truncate)",
                 n_accepted, req_tally[REQ_APPEND], req_tally[REQ_DEFAULTS],
                 req_tally[REQ_READ], req_tally[REQ_TRUNC]);
        $display("summary: %0d results checked, %0d ok, %0d range errors, %0d table full",
                 n_checked, st_tally[ST_OK], st_tally[ST_RANGE], st_tally[ST_FULL]);
        if (errors == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/scs_pkg.sv
rtl/scs_alu.sv
rtl/scs_store.sv
rtl/scs_seq.sv
rtl/sparse_column_store.sv
dv/tb_sparse_column_store.sv
